// ===== rtl/integer_to_decimal_ascii_macros.svh =====
// Assertion macros for the integer_to_decimal_ascii RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef INTEGER_TO_DECIMAL_ASCII_MACROS_SVH
`define INTEGER_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define I2DA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define I2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/i2da_pkg.sv =====
// Shared types, constants and the power-of-ten table for the decimal printer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2da_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int NUM_DIGITS  = 10;
  localparam int POS_W       = 4;

  localparam logic [5:0] CHAR_MINUS = 6'd45;  // '-'
  localparam logic [5:0] CHAR_ZERO  = 6'd48;  // '0'

  typedef struct packed {
    logic [31:0] value;
    logic        is_signed;
  } in_item_t;

  typedef struct packed {
    logic [5:0] character;
    logic       last;
  } out_item_t;

  // Classified item: magnitude and sign flag.
  typedef struct packed {
    logic [31:0] mag;
    logic        neg;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_req_t;

  // 10**k for k = 0..10, 34 bits wide so that 9 * 10**9 also fits.
  function automatic logic [33:0] pow10(input logic [POS_W-1:0] k);
    logic [33:0] p;
    unique case (k)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      4'd10:   p = 34'd10000000000;
      default: p = 34'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/i2da_front.sv =====
// Front end: takes input items, forms sign and magnitude, queues the result.
// Depends on i2da_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2da_front
  import i2da_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire in_item_t in_item,
  output logic          full,
  output job_req_t      job_req,
  input  wire logic     job_take
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;
  job_t             cls;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = job_take && (count_r != '0);

  // Negative only in signed mode; 0 - value also covers the most negative word.
  always_comb begin
    cls.neg = in_item.is_signed && in_item.value[31];
    cls.mag = cls.neg ? (32'd0 - in_item.value) : in_item.value;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  assign job_req.valid = (count_r != '0);
  assign job_req.job   = q_mem[rd_ptr_r];

endmodule

`default_nettype wire

// ===== rtl/i2da_back.sv =====
// Back end: one decimal digit per cycle unless the output register is held, MSD first, into a one-item output register.
// Depends on i2da_pkg and integer_to_decimal_ascii_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_decimal_ascii_macros.svh"

module i2da_back
  import i2da_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire job_req_t job_req,
  output logic          job_take,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     out_item
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SIGN  = 2'd1;
  localparam logic [1:0] ST_DIGIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             started_r, started_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic        slot_free;
  logic        emit_now;
  logic [3:0]  digit;
  logic [33:0] pow;
  logic [33:0] sub;

  assign slot_free = !out_valid_r || pop;

  // Digit at position pos_r: count of multiples c * 10**pos that fit in rem_r.
  always_comb begin
    logic [33:0] mult;
    pow   = pow10(pos_r);
    digit = 4'd0;
    sub   = 34'd0;
    for (int c = 1; c < 10; c++) begin
      mult = pow * 34'(c);
      if ({2'b00, rem_r} >= mult) begin
        digit = 4'(c);
        sub   = mult;
      end
    end
  end

  // Leading zeros are skipped; the units digit always prints.
  assign emit_now = started_r || (digit != 4'd0) || (pos_r == '0);

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !pop;
    out_data_nxt  = out_data_r;
    job_take      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (job_req.valid) begin
          job_take    = 1'b1;
          rem_nxt     = job_req.job.mag;
          pos_nxt     = POS_W'(NUM_DIGITS - 1);
          started_nxt = 1'b0;
          state_nxt   = job_req.job.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.character = CHAR_MINUS;
          out_data_nxt.last      = 1'b0;
          state_nxt              = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (!emit_now || slot_free) begin
          rem_nxt = 32'(({2'b00, rem_r}) - sub);
          pos_nxt = pos_r - POS_W'(1);
          if (emit_now) begin
            started_nxt            = 1'b1;
            out_valid_nxt          = 1'b1;
            out_data_nxt.character = CHAR_ZERO + {2'b00, digit};
            out_data_nxt.last      = (pos_r == '0);
          end
          if (pos_r == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign empty    = !out_valid_r;
  assign out_item = out_data_r;

  `I2DA_ASSERT_NOW(a_rem_bound, state_r == ST_DIGIT,
                   {2'b00, rem_r} < pow10(4'(pos_r + POS_W'(1))),
                   "remainder exceeds digit position")
  `I2DA_ASSERT_NEXT(a_done_idle, state_r == ST_DIGIT && pos_r == '0 && slot_free,
                    state_r == ST_IDLE, "conversion did not finish at units digit")
  `I2DA_ASSERT_NOW(a_last_units,
                   out_valid_nxt && out_data_nxt.last && !(out_valid_r && !pop),
                   state_r == ST_DIGIT && pos_r == '0, "last marked away from units digit")

endmodule

`default_nettype wire

// ===== rtl/integer_to_decimal_ascii.sv =====
// Top level of the decimal ASCII printer: front classifier/queue plus back converter.
// Depends on i2da_pkg, i2da_front and i2da_back.
//
//   channel | ports                      | accepted when
//   --------+----------------------------+---------------------
//   input   | push, full, in_item        | push && !full
//   result  | empty, pop, out_item       | pop && !empty
//
// The converter loads each item, then emits the '-' of a negative value, then steps
// through 10 digit positions, most significant first.
// Leading-zero positions are stepped through but produce no result item.
// Two classified items queue ahead of the converter. A held-off result stalls the
// converter first; full rises only once both queue slots are taken. Reset is synchronous.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_decimal_ascii
  import i2da_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item,
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     out_item
);

  job_req_t job_req;
  logic     job_take;

  // Sign/magnitude classification and the short item queue.
  i2da_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_item  (in_item),
    .full     (full),
    .job_req  (job_req),
    .job_take (job_take)
  );

  // Digit sequencer and output register.
  i2da_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_req  (job_req),
    .job_take (job_take),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for integer_to_decimal_ascii: predicts the decimal text of each word and
// checks every character against it. Depends on i2da_pkg and the integer_to_decimal_ascii RTL.
`timescale 1ns / 1ps

module tb;
  import i2da_pkg::*;

  // Cycles without any accepted item before the run is called hung.
  localparam int STALL_LIMIT = 3000;
  // Long receiver hold-off, long enough to back the block up into its input.
  localparam int HOLD_CYCLES = 200;
  // Settle time after the last character, about two conversions.
  localparam int TAIL_CYCLES = 30;

  // Expected characters of every number in flight, oldest first.
  class digit_ledger;
    out_item_t pending_chars[$];
    int        errors = 0;

    // Spell out one accepted word as decimal characters.
    function void note_number(in_item_t it);
      logic [31:0] mag;
      logic [3:0]  digs[$];
      bit          neg;
      neg = it.is_signed && it.value[31];
      mag = neg ? 32'd0 - it.value : it.value;  // most negative word wraps to 2^31 as unsigned
      if (mag == 32'd0) begin
        digs.push_back(4'd0);
      end
      while (mag != 32'd0) begin
        digs.push_front(4'(mag % 32'd10));
        mag = mag / 32'd10;
      end
      if (neg) begin
        pending_chars.push_back(out_item_t'{character: CHAR_MINUS, last: 1'b0});
      end
      foreach (digs[i]) begin
        pending_chars.push_back(out_item_t'{character: CHAR_ZERO + 6'(digs[i]),
                                            last: (i == digs.size() - 1)});
      end
    endfunction

    function void check_char(out_item_t got);
      out_item_t want;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual char=%0d last=%0b",
                 $time, got.character, got.last);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (got.character !== want.character) begin
        $display("%0t: character: expected %0d, actual %0d", $time, want.character,
                 got.character);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last: expected %0b, actual %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_chars.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  in_item = '0;
  logic      full;
  logic      empty;
  out_item_t out_item;

  digit_ledger book = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;   // raised by the stimulus, cleared by the receiver
  int quiet_cycles = 0;

  integer_to_decimal_ascii dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Monitor: note accepted words before checking characters so ordering is fixed.
  // Outputs and handshakes are read at the edge, before any NBA update lands.
  always @(posedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (push && !full) begin
        book.note_number(in_item);
        moved = 1'b1;
      end
      if (pop && !empty) begin
        book.check_char(out_item);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
        $display("integer_to_decimal_ascii: mismatch");
        $finish;
      end
    end
  end

  // Receiver: random pop, or a long hold-off when the stimulus asks for one.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one word; push stays high afterward unless the sender decides to idle.
  task automatic send_number(input logic [31:0] v, input bit s);
    in_item <= in_item_t'{value: v, is_signed: s};
    push    <= 1'b1;
    do @(posedge clk); while (full);
    // Each following cycle idles with the chosen odds.
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (book.outstanding() != 0) @(posedge clk);
  endtask

  // Mix of full-range words, short words, narrow sign-extended values and
  // powers of ten plus or minus one, so digit counts are spread out.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    logic [31:0] p;
    int          k;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(31);
      2: begin
        v = $urandom;
        v = $urandom_range(1) ? {{24{v[7]}}, v[7:0]} : {{16{v[15]}}, v[15:0]};
      end
      default: begin
        p = 32'd1;
        k = $urandom_range(9);
        repeat (k) p = p * 32'd10;
        v = p + $urandom_range(2) - 1;
        if ($urandom_range(1)) v = 32'd0 - v;
      end
    endcase
    return v;
  endfunction

  task automatic random_burst(input int n);
    repeat (n) send_number(pick_value(), $urandom_range(1));
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase 1: sender idles now and then, receiver mostly stalls.
    send_idle_pct = 21;
    recv_idle_pct = 73;

    // Directed: zero, single digits, decade edges, top of range both ways.
    send_number(32'd0, 1'b0);
    send_number(32'd0, 1'b1);
    send_number(32'd1, 1'b0);
    send_number(32'd9, 1'b1);
    send_number(32'd10, 1'b0);
    send_number(32'd99, 1'b0);
    send_number(32'd100, 1'b1);
    send_number(32'd999999999, 1'b0);
    send_number(32'd1000000000, 1'b0);
    send_number(32'h7FFF_FFFF, 1'b1);
    send_number(32'h7FFF_FFFF, 1'b0);
    send_number(32'h8000_0000, 1'b1);   // most negative word, eleven characters
    send_number(32'h8000_0000, 1'b0);   // bit 31 set but unsigned
    send_number(32'hFFFF_FFFF, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b1);   // minus one
    send_number(32'd4000000000, 1'b0);
    send_number(32'hFFFF_FFF6, 1'b1);   // minus ten
    send_number(32'hFFFF_FF80, 1'b1);   // 8-bit -128, sign-extended
    send_number(32'h0000_00FF, 1'b0);   // 8-bit 255, zero-extended
    send_number(32'hFFFF_8000, 1'b1);   // 16-bit -32768
    send_number(32'h0000_FFFF, 1'b0);   // 16-bit 65535
    send_number(32'h5555_5555, 1'b1);
    send_number(32'hAAAA_AAAA, 1'b0);

    random_burst(125);
    drain();

    // Phase 2: roles swapped.
    send_idle_pct = 73;
    recv_idle_pct = 21;
    random_burst(130);
    drain();

    // Phase 3: no idling, opened by a long receiver hold-off so the block backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    random_burst(135);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.errors == 0 && book.outstanding() == 0) begin
      $display("integer_to_decimal_ascii: match");
    end else begin
      if (book.outstanding() != 0) begin
        $display("%0t: %0d expected characters never arrived", $time, book.outstanding());
      end
      $display("integer_to_decimal_ascii: mismatch");
    end
    $finish;
  end

endmodule
